[rtl/core/ged_pkg.sv]
// Shared types and constants of the gradient edge threshold block.
package ged_pkg;

    localparam int INT_W    = 10;
    localparam int COORD_W  = 12;
    localparam int DIM_W    = 13;
    localparam int DIM_MAX  = 4096;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = 13'd480;
    localparam logic [INT_W-1:0] EDGE_THRESHOLD_RST = 10'd64;

    localparam logic [7:0] WHITE = 8'd255;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_column;
        logic               last_of_run;
    } result_t;

endpackage

[rtl/core/gradient_edge_threshold_top.sv]
// Top level of the gradient edge threshold block: line memories, gradient stage, result queue.
//
// Pixels enter on the pixel channel (pixel_valid, pixel_stall, pixel) in raster order,
// one word per pixel. Results leave on the result channel (result_valid, result_stall,
// result), each word carrying its colour, row, column and last_of_run.
// A pixel on row i yields the result for row i-1 at the same column; a pixel on the
// last row also yields itself after that. Pixels of the first row (unless it is also
// the last) yield nothing.
// Throughput: one pixel per clock while the receiver does not stall; on the last row of a
// frame two result words per pixel, so there the result port, not the input, sets the pace.
// The rate is set by the single write port of the line memories (one column per clock) and
// by the one-word result port. The line memories also read one column ahead of the pixel.
// Frame size and threshold are set over the APB port; write them only while idle (not enforced).
// Reset restores the register defaults and sets the position to row 0, column 0; the
// line memories are not cleared, and no result uses what they hold before the first frame has
// filled them.
// A stalled receiver holds the current result word; the pipeline backs up and raises
// pixel_stall once the compute stage can no longer hand its results on.
module gradient_edge_threshold_top
    import ged_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  pixel_t             pixel,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int LINE_DEPTH = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [INT_W-1:0]   edge_threshold_reg;
    logic               cfg_write;

    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;

    logic [COORD_W-1:0] row_count_reg;
    logic [COORD_W-1:0] row_count_next;
    logic [COORD_W-1:0] column_count_reg;
    logic [COORD_W-1:0] column_count_next;

    logic               accept;
    logic [23:0]        pixel_rgb;
    logic [INT_W-1:0]   pixel_int;
    logic [COORD_W-1:0] col;
    logic [DIM_W-1:0]   col_plus;
    logic [ADDR_W-1:0]  addr_near;
    logic [ADDR_W-1:0]  addr_right;
    logic               is_last_row;
    logic               is_interior;

    logic [2*INT_W-1:0] int_mem [LINE_DEPTH];
    logic [23:0]        colour_mem [LINE_DEPTH];
    logic [2*INT_W-1:0] near_rd_reg;
    logic [2*INT_W-1:0] right_rd_reg;
    logic [23:0]        colour_rd_reg;

    logic               s1_valid_reg;
    logic [23:0]        s1_rgb_reg;
    logic [INT_W-1:0]   s1_int_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic [COORD_W-1:0] s1_col_reg;
    logic               s1_par_reg;
    logic               s1_last_row_reg;
    logic               s1_has_prev_reg;
    logic               s1_interior_reg;
    logic [INT_W-1:0]   left_reg;

    logic [INT_W-1:0]   mid;
    logic [INT_W-1:0]   upper;
    logic [INT_W-1:0]   right;
    logic [INT_W-1:0]   diff_right;
    logic [INT_W-1:0]   diff_left;
    logic [INT_W-1:0]   diff_upper;
    logic [INT_W-1:0]   diff_lower;
    logic [INT_W-1:0]   max_a;
    logic [INT_W-1:0]   max_b;
    logic [INT_W-1:0]   max_diff;
    logic [23:0]        first_rgb;
    result_t            first_word;
    result_t            second_word;
    logic               s1_has_results;
    logic               s1_go;

    logic [1:0]         s2_cnt_reg;
    result_t            s2_word0_reg;
    result_t            s2_word1_reg;
    logic               out_fire;
    logic               s2_free;

    function automatic logic [INT_W-1:0] abs_diff(input logic [INT_W-1:0] a,
                                                  input logic [INT_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:    frame_width_reg    <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= pwdata[DIM_W-1:0];
                REG_EDGE_THRESHOLD: edge_threshold_reg <= pwdata[INT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:    prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT:   prdata = PDATA_W'(frame_height_reg);
            REG_EDGE_THRESHOLD: prdata = PDATA_W'(edge_threshold_reg);
            default:            prdata = '0;
        endcase
    end

    // effective frame size
    always_comb
    begin
        width_eff = frame_width_reg;
        if (frame_width_reg == '0)
            width_eff = DIM_W'(1);
        else if (frame_width_reg > DIM_W'(LINE_DEPTH))
            width_eff = DIM_W'(LINE_DEPTH);
        height_eff = frame_height_reg;
        if (frame_height_reg == '0)
            height_eff = DIM_W'(1);
        else if (frame_height_reg > DIM_W'(DIM_MAX))
            height_eff = DIM_W'(DIM_MAX);
    end

    // input side
    assign accept    = pixel_valid & ~pixel_stall;
    assign pixel_rgb = {pixel.in_red, pixel.in_green, pixel.in_blue};
    assign pixel_int = INT_W'(pixel.in_red) + INT_W'(pixel.in_green) + INT_W'(pixel.in_blue);

    always_comb
    begin
        col = ({1'b0, column_count_reg} < DIM_W'(LINE_DEPTH)) ? column_count_reg : '0;
        col_plus    = {1'b0, col} + DIM_W'(1);
        addr_near   = col[ADDR_W-1:0];
        addr_right  = (col_plus < DIM_W'(LINE_DEPTH)) ? col_plus[ADDR_W-1:0] : addr_near;
        is_last_row = ({1'b0, row_count_reg} + DIM_W'(1)) >= height_eff;
        is_interior = (row_count_reg >= COORD_W'(2)) && ({1'b0, row_count_reg} < height_eff)
                      && (col != '0) && (col_plus < width_eff);
    end

    always_comb
    begin
        if (({1'b0, column_count_reg} + DIM_W'(1)) >= width_eff)
        begin
            column_count_next = '0;
            if (is_last_row)
                row_count_next = '0;
            else
                row_count_next = row_count_reg + COORD_W'(1);
        end
        else
        begin
            column_count_next = column_count_reg + COORD_W'(1);
            row_count_next    = row_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= '0;
            column_count_reg <= '0;
        end
        else if (accept)
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
        end
    end

    // line memories: read first, then write this pixel's column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            near_rd_reg          <= int_mem[addr_near];
            right_rd_reg         <= int_mem[addr_right];
            colour_rd_reg        <= colour_mem[addr_near];
            colour_mem[addr_near] <= pixel_rgb;
            if (row_count_reg[0])
                int_mem[addr_near][2*INT_W-1:INT_W] <= pixel_int;
            else
                int_mem[addr_near][INT_W-1:0] <= pixel_int;
        end
    end

    // gradient stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rgb_reg      <= pixel_rgb;
            s1_int_reg      <= pixel_int;
            s1_row_reg      <= row_count_reg;
            s1_col_reg      <= col;
            s1_par_reg      <= row_count_reg[0];
            s1_last_row_reg <= is_last_row;
            s1_has_prev_reg <= (row_count_reg != '0);
            s1_interior_reg <= is_interior;
            left_reg        <= mid;
        end
    end

    always_comb
    begin
        mid   = s1_par_reg ? near_rd_reg[INT_W-1:0] : near_rd_reg[2*INT_W-1:INT_W];
        upper = s1_par_reg ? near_rd_reg[2*INT_W-1:INT_W] : near_rd_reg[INT_W-1:0];
        right = s1_par_reg ? right_rd_reg[INT_W-1:0] : right_rd_reg[2*INT_W-1:INT_W];

        diff_right = abs_diff(mid, right);
        diff_left  = abs_diff(mid, left_reg);
        diff_upper = abs_diff(mid, upper);
        diff_lower = abs_diff(mid, s1_int_reg);
        max_a      = (diff_left > diff_right) ? diff_left : diff_right;
        max_b      = (diff_lower > diff_upper) ? diff_lower : diff_upper;
        max_diff   = (max_b > max_a) ? max_b : max_a;

        if (!s1_interior_reg)
            first_rgb = colour_rd_reg;
        else if (max_diff < edge_threshold_reg)
            first_rgb = {WHITE, WHITE, WHITE};
        else
            first_rgb = '0;

        first_word.out_red     = first_rgb[23:16];
        first_word.out_green   = first_rgb[15:8];
        first_word.out_blue    = first_rgb[7:0];
        first_word.out_row     = s1_row_reg - COORD_W'(1);
        first_word.out_column  = s1_col_reg;
        first_word.last_of_run = ~s1_last_row_reg;

        second_word.out_red     = s1_rgb_reg[23:16];
        second_word.out_green   = s1_rgb_reg[15:8];
        second_word.out_blue    = s1_rgb_reg[7:0];
        second_word.out_row     = s1_row_reg;
        second_word.out_column  = s1_col_reg;
        second_word.last_of_run = 1'b1;
    end

    assign s1_has_results = s1_has_prev_reg | s1_last_row_reg;
    assign s1_go          = s1_valid_reg & (~s1_has_results | s2_free);
    assign pixel_stall    = s1_valid_reg & ~s1_go;

    // result queue
    assign result_valid = (s2_cnt_reg != 2'd0);
    assign result       = s2_word0_reg;
    assign out_fire     = result_valid & ~result_stall;
    assign s2_free      = (s2_cnt_reg == 2'd0) || ((s2_cnt_reg == 2'd1) && out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_cnt_reg <= 2'd0;
        else if (s1_go && s1_has_results)
            s2_cnt_reg <= (s1_has_prev_reg && s1_last_row_reg) ? 2'd2 : 2'd1;
        else if (out_fire)
            s2_cnt_reg <= s2_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_has_results)
        begin
            s2_word0_reg <= s1_has_prev_reg ? first_word : second_word;
            s2_word1_reg <= second_word;
        end
        else if (out_fire)
            s2_word0_reg <= s2_word1_reg;
    end

endmodule

[rtl/core/ged_checker.sv]
// Port checker of the gradient edge threshold block and its bind.
module ged_checker
    import ged_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    pixel_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result word changed while stalled");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last_of_run |=>
            result_valid && result.last_of_run
            && (result.out_column == $past(result.out_column))
            && (result.out_row == COORD_W'($past(result.out_row) + COORD_W'(1))))
        else $error("last-row word does not follow its upper neighbour");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !pixel_stall)
        else $error("pixel stalled with result queue empty");

endmodule

bind gradient_edge_threshold_top ged_checker u_ged_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[tb/gradient_edge_threshold_top_test.sv]
// Self-checking testbench of the gradient edge threshold block: framed pixel streams, checked results.
module gradient_edge_threshold_top_test;
    import ged_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned DRAIN       = 8;
    localparam int unsigned HOLD_OFF    = 300;
    localparam int unsigned PHASE_WORDS = 300;

    class edge_board;
        bit [INT_W-1:0]   lum_rows [0:2*DIM_MAX-1];
        bit [23:0]        prev_colours [0:DIM_MAX-1];
        bit [COORD_W-1:0] row_pos;
        bit [COORD_W-1:0] col_pos;
        bit [DIM_W-1:0]   width_reg;
        bit [DIM_W-1:0]   height_reg;
        bit [INT_W-1:0]   thresh_reg;
        result_t          owed [$];
        int unsigned      errors;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            thresh_reg = EDGE_THRESHOLD_RST;
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            return (v == 0) ? 1 : ((v > DIM_MAX) ? DIM_MAX : v);
        endfunction

        function int unsigned gap(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction

        function void set_register(logic [1:0] idx, logic [PDATA_W-1:0] v);
            case (idx)
                REG_FRAME_WIDTH:    width_reg  = v[DIM_W-1:0];
                REG_FRAME_HEIGHT:   height_reg = v[DIM_W-1:0];
                REG_EDGE_THRESHOLD: thresh_reg = v[INT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PDATA_W-1:0] register_value(logic [1:0] idx);
            case (idx)
                REG_FRAME_WIDTH:    return PDATA_W'(width_reg);
                REG_FRAME_HEIGHT:   return PDATA_W'(height_reg);
                REG_EDGE_THRESHOLD: return PDATA_W'(thresh_reg);
                default:            return '0;
            endcase
        endfunction

        function void take_pixel(pixel_t px);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned cur;
            int unsigned mid;
            int unsigned grad;
            int unsigned own_base;
            int unsigned upper_base;
            logic [23:0] colour;
            logic [23:0] shade;
            bit          last_row;
            result_t     r;
            w          = clamp_dim(width_reg);
            h          = clamp_dim(height_reg);
            colour     = {px.in_red, px.in_green, px.in_blue};
            cur        = px.in_red + px.in_green + px.in_blue;
            c          = col_pos;
            own_base   = row_pos[0] ? DIM_MAX : 0;
            upper_base = row_pos[0] ? 0 : DIM_MAX;
            last_row   = (row_pos + 1 >= h);
            if (row_pos != 0)
            begin
                shade = prev_colours[c];
                if (row_pos >= 2 && row_pos < h && c >= 1 && c + 1 < w)
                begin
                    mid  = lum_rows[upper_base + c];
                    grad = gap(mid, lum_rows[upper_base + c + 1]);
                    if (gap(mid, lum_rows[upper_base + c - 1]) > grad)
                        grad = gap(mid, lum_rows[upper_base + c - 1]);
                    if (gap(mid, lum_rows[own_base + c]) > grad)
                        grad = gap(mid, lum_rows[own_base + c]);
                    if (gap(mid, cur) > grad)
                        grad = gap(mid, cur);
                    shade = (grad < thresh_reg) ? {WHITE, WHITE, WHITE} : 24'd0;
                end
                r.out_red     = shade[23:16];
                r.out_green   = shade[15:8];
                r.out_blue    = shade[7:0];
                r.out_row     = row_pos - 1'b1;
                r.out_column  = c[COORD_W-1:0];
                r.last_of_run = !last_row;
                owed.push_back(r);
            end
            if (last_row)
            begin
                r.out_red     = px.in_red;
                r.out_green   = px.in_green;
                r.out_blue    = px.in_blue;
                r.out_row     = row_pos;
                r.out_column  = c[COORD_W-1:0];
                r.last_of_run = 1'b1;
                owed.push_back(r);
            end
            lum_rows[own_base + c] = cur[INT_W-1:0];
            prev_colours[c]        = colour;
            if (col_pos + 1 >= w)
            begin
                col_pos = '0;
                if (row_pos + 1 >= h)
                    row_pos = '0;
                else
                    row_pos = row_pos + 1'b1;
            end
            else
                col_pos = col_pos + 1'b1;
        endfunction

        function void compare(string field, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed.size() == 0)
            begin
                $error("result word with nothing due: row %0d column %0d",
                       got.out_row, got.out_column);
                errors++;
                return;
            end
            want = owed.pop_front();
            compare("out_red", want.out_red, got.out_red);
            compare("out_green", want.out_green, got.out_green);
            compare("out_blue", want.out_blue, got.out_blue);
            compare("out_row", want.out_row, got.out_row);
            compare("out_column", want.out_column, got.out_column);
            compare("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               pixel_valid  = 1'b0;
    logic               pixel_stall;
    pixel_t             pixel        = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_t            result;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [PDATA_W-1:0] pwdata       = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    edge_board   board = new();
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_cnt           = 0;
    int unsigned reg_mismatches     = 0;
    bit          busy_image         = 1'b1;
    int unsigned tone_span          = 0;
    int unsigned tone_base [3];

    pixel_t rim_set [0:8] = '{24'h123456, 24'hFFFFFF, 24'hFF0000,
                              24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                              24'h00FF00, 24'hFFFFFF, 24'h0000FF};

    gradient_edge_threshold_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cnt > 0)
            begin
                result_stall <= 1'b1;
                hold_cnt--;
            end
            else
                result_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic pixel_t make_pixel();
        pixel_t p;
        if (busy_image)
            p = pixel_t'($urandom);
        else
        begin
            p.in_red   = 8'(tone_base[0] + $urandom_range(tone_span));
            p.in_green = 8'(tone_base[1] + $urandom_range(tone_span));
            p.in_blue  = 8'(tone_base[2] + $urandom_range(tone_span));
        end
        return p;
    endfunction

    // pick the look of the next image and a threshold that suits it
    function automatic int unsigned pick_content();
        busy_image = ($urandom_range(2) == 0);
        tone_span  = $urandom_range(12);
        foreach (tone_base[k])
            tone_base[k] = $urandom_range(255 - tone_span);
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1023;
            default: return busy_image ? $urandom_range(800) : $urandom_range(3 * tone_span + 2);
        endcase
    endfunction

    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            pixel       <= pixel_t'($urandom);
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do
            @(posedge clk);
        while (pixel_stall);
        board.take_pixel(p);
        @(negedge clk);
    endtask

    task automatic run_pixels(input int unsigned n);
        repeat (n)
            send_pixel(make_pixel());
    endtask

    task automatic settle();
        pixel_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN)
            @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] word;
        word    = value | ($urandom << DIM_W);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_register(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_register(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== board.register_value(idx))
        begin
            $error("register %0d: expected %0d, got %0d", idx, board.register_value(idx), prdata);
            reg_mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_registers();
        check_register(REG_FRAME_WIDTH);
        check_register(REG_FRAME_HEIGHT);
        check_register(REG_EDGE_THRESHOLD);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned thr);
        settle();
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        apb_write(REG_EDGE_THRESHOLD, thr);
        check_registers();
    endtask

    task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned thr);
        configure(w, h, thr);
        run_pixels(board.clamp_dim(w) * board.clamp_dim(h));
    endtask

    initial
    begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned thr;
        int unsigned words;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        check_registers();

        // zero sizes collapse to a single pixel
        configure(0, 0, 0);
        apb_write(REG_UNUSED, $urandom);
        check_registers();
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hA55AC3);

        configure(3, 3, 1023);
        foreach (rim_set[k])
            send_pixel(rim_set[k]);
        configure(3, 3, 0);
        repeat (9)
            send_pixel(24'h808080);

        thr = pick_content();
        run_frame(32, 1, thr);
        thr = pick_content();
        run_frame(1, 32, thr);

        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 83;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 83;
                end
                default:
                begin
                    sender_idle_pct    = 7;
                    receiver_stall_pct = 7;
                end
            endcase
            words = 0;
            if (mode == 0)
            begin
                configure(12, 8, pick_content());
                hold_cnt = HOLD_OFF;
                run_pixels(96);
                words += 96;
            end
            if (mode == 2)
            begin
                // shrink the width while the column sits beyond it
                configure(10, 4, pick_content());
                run_pixels(7);
                settle();
                apb_write(REG_FRAME_WIDTH, 4);
                run_pixels(13);
                // shrink the height while the row sits beyond it
                configure(5, 6, pick_content());
                run_pixels(15);
                settle();
                apb_write(REG_FRAME_HEIGHT, 2);
                run_pixels(5);
                words += 40;
            end
            while (words < PHASE_WORDS)
            begin
                w   = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                h   = $urandom_range(1, 8);
                thr = pick_content();
                run_frame(w, h, thr);
                words += w * h;
            end
        end

        pixel_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN)
            @(negedge clk);
        if (board.errors == 0 && reg_mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
